// ----- rtl/sac_pkg.sv -----
`timescale 1ns / 1ps

package sac_pkg;

  // Width of one character and of one configured letter.
  localparam int CharW = 8;

  // Width of the letter count and of the claim counter.
  localparam int CountW = 6;

  // Number of 64-bit letter registers and the width of one of them.
  localparam int LetterRegs = 5;
  localparam int LetterRegW = 64;

  // Width of the configuration register index.
  localparam int CfgIndexW = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    REG_LETTERS_0_TO_7   = 3'd0,
    REG_LETTERS_8_TO_15  = 3'd1,
    REG_LETTERS_16_TO_23 = 3'd2,
    REG_LETTERS_24_TO_31 = 3'd3,
    REG_LETTERS_32_TO_39 = 3'd4,
    REG_LETTER_COUNT     = 3'd5
  } cfg_reg_t;

  // One character transaction as it travels down the chain of cells.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             has_char;
    logic             end_of_word;
    logic             claimed;
  } sac_item_t;

endpackage

// ----- rtl/sac_cell.sv -----
`timescale 1ns / 1ps

module sac_cell
  import sac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [CharW-1:0] letter,
  input  logic             active,
  input  logic             prev_valid,
  input  sac_item_t        prev_item,
  output logic             next_valid,
  output sac_item_t        next_item
);

  logic      mark_r;
  logic      mark_nxt;
  logic      valid_r;
  logic      valid_nxt;
  sac_item_t item_r;
  sac_item_t item_nxt;
  logic      take;

  // A character that is still unclaimed takes this letter if the cell is active, free and equal.
  assign take = prev_valid && prev_item.has_char && !prev_item.claimed &&
                active && !mark_r && (letter == prev_item.ch);

  // Mark, valid and payload update; the end of a word clears the mark after its own character.
  always_comb begin
    mark_nxt  = mark_r;
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (advance) begin
      valid_nxt = prev_valid;
      item_nxt  = prev_item;
      if (take) begin
        mark_nxt         = 1'b1;
        item_nxt.claimed = 1'b1;
      end
      if (prev_valid && prev_item.end_of_word) begin
        mark_nxt = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      mark_r  <= mark_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload register handed to the next cell.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign next_valid = valid_r;
  assign next_item  = item_r;

endmodule

// ----- rtl/sac_tail.sv -----
`timescale 1ns / 1ps

module sac_tail
  import sac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              last_valid,
  input  sac_item_t         last_item,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_anagram,
  output logic [CountW-1:0] out_letters_consumed
);

  logic              word_failed_r;
  logic              word_failed_nxt;
  logic [CountW-1:0] claimed_count_r;
  logic [CountW-1:0] claimed_count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              is_anagram_r;
  logic              is_anagram_nxt;
  logic [CountW-1:0] consumed_r;
  logic [CountW-1:0] consumed_nxt;
  logic              fail_now;
  logic [CountW-1:0] count_now;

  // The chain moves whenever the output register is free or being emptied.
  assign advance = !out_valid_r || out_ready;

  // Word verdict including the character leaving the chain.
  always_comb begin
    fail_now  = word_failed_r;
    count_now = claimed_count_r;
    if (last_item.has_char && !word_failed_r) begin
      if (last_item.claimed) begin
        count_now = claimed_count_r + CountW'(1);
      end else begin
        fail_now = 1'b1;
      end
    end
  end

  // Word state and output register.
  always_comb begin
    word_failed_nxt   = word_failed_r;
    claimed_count_nxt = claimed_count_r;
    out_valid_nxt     = out_valid_r;
    is_anagram_nxt    = is_anagram_r;
    consumed_nxt      = consumed_r;
    if (advance) begin
      out_valid_nxt = last_valid && last_item.end_of_word;
      if (last_valid) begin
        if (last_item.end_of_word) begin
          is_anagram_nxt    = !fail_now;
          consumed_nxt      = count_now;
          word_failed_nxt   = 1'b0;
          claimed_count_nxt = '0;
        end else begin
          word_failed_nxt   = fail_now;
          claimed_count_nxt = count_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_failed_r   <= 1'b0;
      claimed_count_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      word_failed_r   <= word_failed_nxt;
      claimed_count_r <= claimed_count_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_anagram_r <= is_anagram_nxt;
    consumed_r   <= consumed_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_is_anagram       = is_anagram_r;
  assign out_letters_consumed = consumed_r;

endmodule

// ----- rtl/sub_anagram_checker_top.sv -----
`timescale 1ns / 1ps
// An accepted end-of-word transaction passes through every cell register and then the output register.
// Throughput: one character transaction per cycle; each of the MAX_LETTERS cells
// compares the passing character against its own letter once, one cell per cycle.
// The whole chain holds while a finished result waits in the output register.
// Reset (synchronous, active low) clears letters, letter count, used marks and valids.

module sub_anagram_checker_top
  import sac_pkg::*;
#(
  parameter int MAX_LETTERS = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CharW-1:0]      in_ch,
  input  logic                  in_has_char,
  input  logic                  in_end_of_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_is_anagram,
  output logic [CountW-1:0]     out_letters_consumed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgIndexW-1:0]  cfg_index,
  input  logic [LetterRegW-1:0] cfg_data
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_LETTERS);

  logic [LetterRegW-1:0]            letter_regs_r [LetterRegs];
  logic [LetterRegs*LetterRegW-1:0] letters_flat;
  logic [CountW-1:0]                letter_count_r;
  logic [CountW-1:0]                active_n;
  logic                             advance;
  logic                             stage_valid [MAX_LETTERS+1];
  sac_item_t                        stage_item  [MAX_LETTERS+1];

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < LetterRegs; r++) begin
        letter_regs_r[r] <= '0;
      end
      letter_count_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LETTERS_0_TO_7:   letter_regs_r[0] <= cfg_data;
        REG_LETTERS_8_TO_15:  letter_regs_r[1] <= cfg_data;
        REG_LETTERS_16_TO_23: letter_regs_r[2] <= cfg_data;
        REG_LETTERS_24_TO_31: letter_regs_r[3] <= cfg_data;
        REG_LETTERS_32_TO_39: letter_regs_r[4] <= cfg_data;
        REG_LETTER_COUNT:     letter_count_r   <= cfg_data[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Flatten the letter registers so that letter i sits in byte i.
  always_comb begin
    for (int r = 0; r < LetterRegs; r++) begin
      letters_flat[r*LetterRegW +: LetterRegW] = letter_regs_r[r];
    end
  end

  // A count above the number of cells acts as the number of cells.
  assign active_n = (letter_count_r > MaxCount) ? MaxCount : letter_count_r;

  // The input transaction enters the first cell unclaimed.
  assign in_ready                 = advance;
  assign stage_valid[0]           = in_valid;
  assign stage_item[0].ch          = in_ch;
  assign stage_item[0].has_char    = in_has_char;
  assign stage_item[0].end_of_word = in_end_of_word;
  assign stage_item[0].claimed     = 1'b0;

  // Chain of cells, one per letter.
  for (genvar i = 0; i < MAX_LETTERS; i++) begin : g_cell
    sac_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .letter     (letters_flat[i*CharW +: CharW]),
      .active     (CountW'(i) < active_n),
      .prev_valid (stage_valid[i]),
      .prev_item  (stage_item[i]),
      .next_valid (stage_valid[i+1]),
      .next_item  (stage_item[i+1])
    );
  end

  // Verdict and output register.
  sac_tail u_tail (
    .clk                  (clk),
    .rst_n                (rst_n),
    .last_valid           (stage_valid[MAX_LETTERS]),
    .last_item            (stage_item[MAX_LETTERS]),
    .advance              (advance),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_is_anagram       (out_is_anagram),
    .out_letters_consumed (out_letters_consumed)
  );

endmodule
